/* src/lkv_pkg.sv */
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the lru key-value cache: table geometry,
// request and response structures and command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

	// table geometry
	localparam int ENTRIES    = 16;
	localparam int KEY_WIDTH  = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int OCC_W      = $clog2(ENTRIES + 1);
	localparam int CAP_W      = 5;
	localparam int CMP_W      = (OCC_W > CAP_W) ? OCC_W : CAP_W;

	// reset value of the capacity register
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	// request kinds
	typedef enum logic {
		CMD_GET = 1'b0,
		CMD_PUT = 1'b1
	} cmd_t;

	// one request as held in the input stage
	typedef struct packed {
		cmd_t                          cmd;
		logic [KEY_WIDTH-1:0]          key;
		logic signed [DATA_WIDTH-1:0]  value;
	} req_t;

	// result of one request
	typedef struct packed {
		logic                          found;
		logic signed [DATA_WIDTH-1:0]  read_value;
	} resp_t;

endpackage

`default_nettype wire

/* src/lkv_table.sv */
// ----------------------------------------------------------------------------
// lkv_table
// Entry storage with parallel key compare and per-entry recency ranks.
// Looks up the request held in the input stage, forms its response and
// updates keys, data, ranks and occupancy at the same clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_table (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_en,
	input  wire lkv_pkg::req_t               req,
	input  wire logic [lkv_pkg::CAP_W-1:0]   capacity,
	output lkv_pkg::resp_t                   resp
);

	localparam int N  = lkv_pkg::ENTRIES;
	localparam int IW = lkv_pkg::IDX_W;
	localparam int OW = lkv_pkg::OCC_W;
	localparam int CW = lkv_pkg::CMP_W;

	// table state
	logic [N-1:0]                        valid_q;
	logic [lkv_pkg::KEY_WIDTH-1:0]       key_q  [N];
	logic signed [lkv_pkg::DATA_WIDTH-1:0] data_q [N];
	logic [IW-1:0]                       rank_q [N];
	logic [OW-1:0]                       occ_q;

	// next-state and write enables
	logic [N-1:0]  valid_d;
	logic [IW-1:0] rank_d [N];
	logic [N-1:0]  wr_key;
	logic [N-1:0]  wr_data;
	logic [OW-1:0] occ_d;

	// lookup signals
	logic [N-1:0]  match;
	logic [N-1:0]  hit_oh;
	logic          hit;
	logic [IW-1:0] hit_rank;
	logic signed [lkv_pkg::DATA_WIDTH-1:0] hit_data;
	logic          is_put;

	// replacement signals
	logic [CW-1:0] eff_cap;
	logic          evict_need;
	logic [OW-1:0] occ_last;
	logic [N-1:0]  victim;
	logic [N-1:0]  victim_oh;
	logic          have_victim;
	logic [N-1:0]  free_oh;
	logic [N-1:0]  slot_oh;

	assign is_put = (req.cmd == lkv_pkg::CMD_PUT);

	// parallel key compare, first match wins
	always_comb begin
		for (int i = 0; i < N; i++) begin
			match[i] = valid_q[i] && (key_q[i] == req.key);
		end
	end
	assign hit_oh = match & (~match + N'(1));
	assign hit    = |match;

	// rank and data of the hit entry
	always_comb begin
		hit_rank = '0;
		hit_data = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_oh[i]) begin
				hit_rank = hit_rank | rank_q[i];
				hit_data = hit_data | data_q[i];
			end
		end
	end

	// effective capacity, clamped to 1..ENTRIES
	always_comb begin
		if (capacity == '0) begin
			eff_cap = CW'(1);
		end else if (CW'(capacity) > CW'(N)) begin
			eff_cap = CW'(N);
		end else begin
			eff_cap = CW'(capacity);
		end
	end
	assign evict_need = (CW'(occ_q) >= eff_cap) && (occ_q != '0);
	assign occ_last   = occ_q - OW'(1);

	// least recent entry as eviction victim
	always_comb begin
		for (int i = 0; i < N; i++) begin
			victim[i] = evict_need && valid_q[i] && (rank_q[i] == occ_last[IW-1:0]);
		end
	end
	assign victim_oh   = victim & (~victim + N'(1));
	assign have_victim = |victim;

	// first free entry and insertion slot
	assign free_oh = (~valid_q) & (valid_q + N'(1));
	assign slot_oh = have_victim ? victim_oh : free_oh;

	// next state of every entry
	always_comb begin
		valid_d = valid_q;
		wr_key  = '0;
		wr_data = '0;
		occ_d   = occ_q;
		for (int i = 0; i < N; i++) begin
			rank_d[i] = rank_q[i];
		end
		if (req_en) begin
			if (hit) begin
				// hit: make the entry most recent, overwrite data on put
				for (int i = 0; i < N; i++) begin
					if (hit_oh[i]) begin
						rank_d[i]  = '0;
						wr_data[i] = is_put;
					end else if (valid_q[i] && (rank_q[i] < hit_rank)) begin
						rank_d[i] = rank_q[i] + IW'(1);
					end
				end
			end else if (is_put) begin
				// miss on put: insert as most recent, everyone else ages
				for (int i = 0; i < N; i++) begin
					if (slot_oh[i]) begin
						valid_d[i] = 1'b1;
						rank_d[i]  = '0;
						wr_key[i]  = 1'b1;
						wr_data[i] = 1'b1;
					end else if (valid_q[i]) begin
						rank_d[i] = rank_q[i] + IW'(1);
					end
				end
				if (!have_victim && (free_oh != '0)) begin
					occ_d = occ_q + OW'(1);
				end
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else begin
			valid_q <= valid_d;
			occ_q   <= occ_d;
		end
	end

	// entry payload
	always_ff @(posedge clk) begin
		for (int i = 0; i < N; i++) begin
			rank_q[i] <= rank_d[i];
			if (wr_key[i]) begin
				key_q[i] <= req.key;
			end
			if (wr_data[i]) begin
				data_q[i] <= req.value;
			end
		end
	end

	// response
	assign resp.found      = hit;
	assign resp.read_value = (hit && !is_put) ? hit_data : '0;

endmodule

`default_nettype wire

/* src/lru_key_value_cache.sv */
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid/in_ready with cmd (0 get, 1 put), key and
//   value. Each request yields one response on out_valid/out_ready with
//   found (key present before the request) and read_value (data on a get
//   hit, else 0). Responses leave in request order.
//   The capacity register is written on cfg_valid/cfg_ready with cfg_data;
//   cfg_ready is always high. Write it only while no request is in flight.
//   A request taken is registered in the input stage, looked up in lkv_table
//   and its response registered in the output register, which drives
//   out_valid. Throughput: one request per cycle while the receiver takes
//   responses, set by the parallel key compare and rank update in lkv_table.
//   When the receiver stalls, one response waits in the output register and
//   one request waits in the input stage; in_ready then drops.
//   Reset empties the table and sets capacity to 16.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                cmd,
	input  wire logic [lkv_pkg::KEY_WIDTH-1:0]       key,
	input  wire logic signed [lkv_pkg::DATA_WIDTH-1:0] value,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     found,
	output logic signed [lkv_pkg::DATA_WIDTH-1:0]    read_value,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lkv_pkg::CAP_W-1:0]           cfg_data
);

	logic                        req_valid_s1;
	lkv_pkg::req_t               req_s1;
	logic                        fire;
	lkv_pkg::resp_t              resp;
	logic [lkv_pkg::CAP_W-1:0]   capacity_q;
	logic                        out_valid_q;
	logic                        found_q;
	logic signed [lkv_pkg::DATA_WIDTH-1:0] read_value_q;

	// input stage advances when the output register is free or emptying
	assign fire     = req_valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !req_valid_s1 || fire;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			req_valid_s1 <= 1'b1;
		end else if (fire) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1.cmd   <= lkv_pkg::cmd_t'(cmd);
			req_s1.key   <= key;
			req_s1.value <= value;
		end
	end

	// capacity register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkv_pkg::CAP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			capacity_q <= cfg_data;
		end
	end

	// lookup and update
	lkv_table u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_en   (fire),
		.req      (req_s1),
		.capacity (capacity_q),
		.resp     (resp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			found_q      <= resp.found;
			read_value_q <= resp.read_value;
		end
	end

	assign out_valid  = out_valid_q;
	assign found      = found_q;
	assign read_value = read_value_q;

endmodule

`default_nettype wire

/* src/lkv_checker.sv */
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the lru key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_checker (
	input wire logic                                clk,
	input wire logic                                arst_n,
	input wire logic                                in_valid,
	input wire logic                                in_ready,
	input wire logic                                cmd,
	input wire logic [lkv_pkg::KEY_WIDTH-1:0]       key,
	input wire logic signed [lkv_pkg::DATA_WIDTH-1:0] value,
	input wire logic                                out_valid,
	input wire logic                                out_ready,
	input wire logic                                found,
	input wire logic signed [lkv_pkg::DATA_WIDTH-1:0] read_value,
	input wire logic                                cfg_valid,
	input wire logic                                cfg_ready,
	input wire logic [lkv_pkg::CAP_W-1:0]           cfg_data
);

	// a stalled response stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("response dropped while stalled");

	// a fresh response comes from a request that passed the input stage and output register
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("response without a request");

	// back-pressure only while a response is stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("request refused without output stall");

	// a miss returns zero data
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (read_value == '0))
		else $error("miss with nonzero data");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

`default_nettype wire

/* tb/lru_key_value_cache_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lru_key_value_cache_tb
// Self-checking bench for the lru key-value cache. A shadow copy of the table
// (keys, data, recency ranks, occupancy and capacity) predicts found and
// read_value for every accepted request. Each response is checked in order
// against that prediction. A short directed run covers empty lookups, key and
// value extremes, overwrites and evictions with the capacity lowered. After
// it, random phases run at several capacities with random gaps on the request
// side and random stalls on the response side.
// ----------------------------------------------------------------------------

module lru_key_value_cache_tb;
	import lkv_pkg::*;

	// shadow table and pending lookup results
	class lru_shadow;
		bit                           slot_used[ENTRIES];
		logic [KEY_WIDTH-1:0]         slot_key[ENTRIES];
		logic signed [DATA_WIDTH-1:0] slot_word[ENTRIES];
		int unsigned                  slot_age[ENTRIES];
		int unsigned                  held;
		logic [CAP_W-1:0]             cap_reg;
		resp_t                        lookup_results[$];
		int unsigned                  mismatches;

		function new();
			for (int i = 0; i < ENTRIES; i++) begin
				slot_used[i] = 1'b0;
				slot_key[i] = '0;
				slot_word[i] = '0;
				slot_age[i] = 0;
			end
			held = 0;
			cap_reg = CAP_RESET;
			mismatches = 0;
		endfunction

		function void set_capacity(logic [CAP_W-1:0] c);
			cap_reg = c;
		endfunction

		// zero acts as one, anything above the table size as the table size
		function int unsigned cap_limit();
			if (cap_reg == 0)
				return 1;
			if (cap_reg > ENTRIES)
				return ENTRIES;
			return cap_reg;
		endfunction

		// move one slot to the front, the ones ahead of it age by one
		function void promote(int s);
			int unsigned old_age;
			old_age = slot_age[s];
			for (int i = 0; i < ENTRIES; i++)
				if (slot_used[i] && slot_age[i] < old_age)
					slot_age[i]++;
			slot_age[s] = 0;
		endfunction

		function void note_request(cmd_t c, logic [KEY_WIDTH-1:0] k,
				logic signed [DATA_WIDTH-1:0] v);
			int    hit;
			int    slot;
			resp_t r;
			hit = -1;
			slot = -1;
			for (int i = 0; i < ENTRIES; i++)
				if (hit < 0 && slot_used[i] && slot_key[i] == k)
					hit = i;
			r.found = (hit >= 0);
			r.read_value = '0;
			if (c == CMD_GET) begin
				if (hit >= 0) begin
					r.read_value = slot_word[hit];
					promote(hit);
				end
			end else if (hit >= 0) begin
				slot_word[hit] = v;
				promote(hit);
			end else begin
				// full: drop the single least recent entry
				if (held >= cap_limit() && held > 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && slot_used[i] && slot_age[i] == held - 1) begin
							slot_used[i] = 1'b0;
							held--;
							slot = i;
						end
				end
				if (slot < 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot < 0 && !slot_used[i])
							slot = i;
				end
				if (slot >= 0) begin
					for (int i = 0; i < ENTRIES; i++)
						if (slot_used[i])
							slot_age[i]++;
					slot_used[slot] = 1'b1;
					slot_key[slot] = k;
					slot_word[slot] = v;
					slot_age[slot] = 0;
					held++;
				end
			end
			lookup_results.push_back(r);
		endfunction

		function void check_response(logic f, logic signed [DATA_WIDTH-1:0] rv);
			resp_t want;
			if (lookup_results.size() == 0) begin
				$error("response with no request pending: found %0d read_value %0d", f, rv);
				mismatches++;
				return;
			end
			want = lookup_results.pop_front();
			if (f !== want.found) begin
				$error("found: expected %0d, actual %0d", want.found, f);
				mismatches++;
			end
			if (rv !== want.read_value) begin
				$error("read_value: expected %0d, actual %0d", want.read_value, rv);
				mismatches++;
			end
		endfunction

		function int unsigned outstanding();
			return lookup_results.size();
		endfunction
	endclass

	logic                         clk = 1'b0;
	logic                         arst_n = 1'b0;
	logic                         in_valid = 1'b0;
	logic                         in_ready;
	cmd_t                         req_cmd = CMD_GET;
	logic [KEY_WIDTH-1:0]         req_key = '0;
	logic signed [DATA_WIDTH-1:0] req_value = '0;
	logic                         out_valid;
	logic                         out_ready = 1'b0;
	logic                         found;
	logic signed [DATA_WIDTH-1:0] read_value;
	logic                         cfg_valid = 1'b0;
	logic                         cfg_ready;
	logic [CAP_W-1:0]             cfg_data = '0;

	lru_shadow shadow = new();

	lru_key_value_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (req_cmd),
		.key        (req_key),
		.value      (req_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.found      (found),
		.read_value (read_value),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data)
	);

	always #10 clk = ~clk;

	// run limit
	initial begin
		#10_000_000;
		$display("lru_key_value_cache test failed");
		$finish;
	end

	// response side: random stall before each response, then wait for it
	initial begin
		int stall;
		wait (arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && out_ready))
				@(posedge clk);
			shadow.check_response(found, read_value);
		end
	end

	// one request, with an optional gap before it
	task automatic send_request(input cmd_t c, input logic [KEY_WIDTH-1:0] k,
			input logic signed [DATA_WIDTH-1:0] v);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_cmd <= c;
		req_key <= k;
		req_value <= v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		shadow.note_request(c, k, v);
	endtask

	task automatic drain_responses();
		in_valid <= 1'b0;
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// capacity write, only issued with the cache idle
	task automatic write_capacity(input logic [CAP_W-1:0] c);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		shadow.set_capacity(c);
		cfg_valid <= 1'b0;
	endtask

	// random phase: keys mostly from a small pool around the capacity so
	// that hits, overwrites and evictions all happen
	task automatic run_phase(input logic [CAP_W-1:0] cap, input int n_items);
		logic [KEY_WIDTH-1:0]         base;
		logic [KEY_WIDTH-1:0]         k;
		logic signed [DATA_WIDTH-1:0] v;
		cmd_t                         c;
		int                           span;
		write_capacity(cap);
		base = KEY_WIDTH'($urandom);
		span = (cap > 20) ? 24 : int'(cap) + 4;
		for (int n = 0; n < n_items; n++) begin
			c = ($urandom_range(0, 99) < 50) ? CMD_PUT : CMD_GET;
			if ($urandom_range(0, 9) == 0)
				k = KEY_WIDTH'($urandom);
			else
				k = base + KEY_WIDTH'($urandom_range(0, span - 1));
			case ($urandom_range(0, 15))
				0: v = 32'sh8000_0000;
				1: v = 32'sh7fff_ffff;
				2: v = -32'sd1;
				3: v = '0;
				default: v = $urandom;
			endcase
			send_request(c, k, v);
		end
		drain_responses();
	endtask

	initial begin
		logic [CAP_W-1:0] caps[10];
		caps = '{5'd31, 5'd1, 5'd17, 5'd8, 5'd0, 5'd3, 5'd16, 5'd2, 5'd12, 5'd5};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, key and value extremes, overwrite, ignored get value
		send_request(CMD_GET, 16'h0000, 32'sd0);
		send_request(CMD_PUT, 16'h0000, 32'sh7fff_ffff);
		send_request(CMD_PUT, 16'hffff, 32'sh8000_0000);
		send_request(CMD_GET, 16'h0000, 32'sd0);
		send_request(CMD_GET, 16'hffff, 32'sd0);
		send_request(CMD_GET, 16'h1234, -32'sd1);
		send_request(CMD_PUT, 16'h0000, -32'sd1);
		send_request(CMD_GET, 16'h0000, 32'sh5555_aaaa);
		send_request(CMD_PUT, 16'h5555, 32'sd0);
		send_request(CMD_PUT, 16'haaaa, 32'sd1);
		drain_responses();

		// capacity lowered below occupancy: one eviction per new key
		write_capacity(5'd2);
		send_request(CMD_PUT, 16'h0001, 32'sd2);
		send_request(CMD_GET, 16'hffff, 32'sd0);
		send_request(CMD_GET, 16'h0000, 32'sd0);
		send_request(CMD_PUT, 16'h0002, 32'sd3);
		send_request(CMD_GET, 16'h5555, 32'sd0);
		send_request(CMD_PUT, 16'h0001, 32'sd4);
		drain_responses();

		// capacity zero behaves as one
		write_capacity(5'd0);
		send_request(CMD_PUT, 16'h0003, 32'sd5);
		send_request(CMD_GET, 16'h0003, 32'sd0);
		send_request(CMD_GET, 16'h0001, 32'sd0);
		send_request(CMD_PUT, 16'h0004, 32'sd6);
		send_request(CMD_GET, 16'h0003, 32'sd0);
		drain_responses();

		for (int p = 0; p < 10; p++)
			run_phase(caps[p], 170);

		drain_responses();
		repeat (5) @(posedge clk);

		if (shadow.mismatches == 0 && shadow.outstanding() == 0)
			$display("lru_key_value_cache test passed");
		else
			$display("lru_key_value_cache test failed");
		$finish;
	end

endmodule

/* lru_key_value_cache.f */
src/lkv_pkg.sv
src/lkv_table.sv
src/lru_key_value_cache.sv
src/lkv_checker.sv
tb/lru_key_value_cache_tb.sv
